@@ sv/cia_pkg.sv @@
`default_nettype none
package cia_pkg;

	localparam int unsigned QueueDepthDef = 4;
	localparam int unsigned DivSteps = 32;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_NOT = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// classified operation handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] a_mag;
		logic [31:0] b_mag;
		logic        a_neg;
		logic        b_neg;
		logic        a_zero;
		logic        b_zero;
		logic        b_m1;
		logic        a_min;
		logic [32:0] sum;
	} fe_item_t;

endpackage
`default_nettype wire

@@ sv/cia_front.sv @@
`default_nettype none
module cia_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        func,
	input  wire logic [31:0]       a,
	input  wire logic [31:0]       b,
	output logic                   push,
	input  wire logic              full,
	output cia_pkg::fe_item_t      item
);
	import cia_pkg::*;

	logic     vld_q;
	fe_item_t item_q;
	fe_item_t item_d;
	logic [32:0] a_ext;
	logic [32:0] b_ext;

	always_comb begin
		a_ext = {a[31], a};
		b_ext = {b[31], b};
		item_d.op     = op_t'(func);
		item_d.a_neg  = a[31];
		item_d.b_neg  = b[31];
		item_d.a_mag  = a[31] ? (32'd0 - a) : a;
		item_d.b_mag  = b[31] ? (32'd0 - b) : b;
		item_d.a_zero = (a == 32'd0);
		item_d.b_zero = (b == 32'd0);
		item_d.b_m1   = (b == 32'hFFFF_FFFF);
		item_d.a_min  = (a == 32'h8000_0000);
		item_d.sum    = (op_t'(func) == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
	end

	assign in_ready = !vld_q || !full;
	assign push     = vld_q && !full;
	assign item     = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/cia_queue.sv @@
`default_nettype none
module cia_queue #(
	parameter int unsigned DEPTH = cia_pkg::QueueDepthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cia_pkg::fe_item_t wr_item,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output cia_pkg::fe_item_t      rd_item
);
	import cia_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fe_item_t        slot_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_item   = slot_q[rp_q];
	assign do_pop    = pop && not_empty;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= nxt(wp_q);
			if (do_pop) rp_q <= nxt(rp_q);
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q) else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

@@ sv/cia_back.sv @@
`default_nettype none
module cia_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_pop,
	input  wire cia_pkg::fe_item_t q_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            result,
	output logic [1:0]             status
);
	import cia_pkg::*;

	localparam int unsigned N = DivSteps;

	typedef struct packed {
		op_t         op;
		logic        a_neg;
		logic        b_neg;
		logic        a_zero;
		logic        b_zero;
		logic        b_m1;
		logic        a_min;
		logic [32:0] sum;
		logic [63:0] prod;
		logic [31:0] rem;
		logic [31:0] dvd;
		logic [31:0] dsr;
	} bk_t;

	logic        vld_q  [N+1];
	bk_t         pipe_q [N+1];
	logic        en;
	logic        out_vld_q;
	logic [31:0] res_q;
	status_t     st_q;
	logic [31:0] res_d;
	status_t     st_d;
	bk_t         fin;
	logic        p_neg;

	// whole pipeline freezes while the output transaction waits
	assign en        = !out_vld_q || out_ready;
	assign q_pop     = en;
	assign out_valid = out_vld_q;
	assign result    = res_q;
	assign status    = st_q;

	// load stage: multiplier and divider setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0].op     <= q_item.op;
			pipe_q[0].a_neg  <= q_item.a_neg;
			pipe_q[0].b_neg  <= q_item.b_neg;
			pipe_q[0].a_zero <= q_item.a_zero;
			pipe_q[0].b_zero <= q_item.b_zero;
			pipe_q[0].b_m1   <= q_item.b_m1;
			pipe_q[0].a_min  <= q_item.a_min;
			pipe_q[0].sum    <= q_item.sum;
			pipe_q[0].prod   <= 64'(q_item.a_mag) * 64'(q_item.b_mag);
			pipe_q[0].rem    <= '0;
			pipe_q[0].dvd    <= q_item.a_mag;
			pipe_q[0].dsr    <= q_item.b_mag;
		end
	end

	// one restoring divide step per stage
	for (genvar k = 0; k < N; k++) begin : g_div
		logic [32:0] trial;
		logic [32:0] diff;
		logic        qbit;
		bk_t         stg_d;

		assign trial = {pipe_q[k].rem, pipe_q[k].dvd[31]};
		assign diff  = trial - {1'b0, pipe_q[k].dsr};
		assign qbit  = !diff[32];

		always_comb begin
			stg_d     = pipe_q[k];
			stg_d.rem = qbit ? diff[31:0] : trial[31:0];
			stg_d.dvd = {pipe_q[k].dvd[30:0], qbit};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_q[k+1] <= stg_d;
			end
		end
	end

	// final select and range checks
	always_comb begin
		fin   = pipe_q[N];
		res_d = '0;
		st_d  = ST_OK;
		p_neg = fin.a_neg ^ fin.b_neg;
		case (fin.op)
			OP_ADD, OP_SUB: begin
				if (!fin.sum[32] && fin.sum[31]) st_d = ST_OVER;
				else if (fin.sum[32] && !fin.sum[31]) st_d = ST_UNDER;
				else res_d = fin.sum[31:0];
			end
			OP_MUL: begin
				if (fin.prod[63:31] == '0) begin
					res_d = p_neg ? (32'd0 - fin.prod[31:0]) : fin.prod[31:0];
				end else if (p_neg && fin.prod[63:31] == 33'd1 && fin.prod[30:0] == '0) begin
					res_d = 32'h8000_0000;
				end else begin
					st_d = ST_OVER;
				end
			end
			OP_DIV: begin
				if (fin.b_zero) st_d = ST_DIVZ;
				else if (fin.a_min && fin.b_m1) st_d = ST_OVER;
				else res_d = p_neg ? (32'd0 - fin.dvd) : fin.dvd;
			end
			OP_MOD: begin
				if (fin.b_zero) st_d = ST_DIVZ;
				else res_d = fin.a_neg ? (32'd0 - fin.rem) : fin.rem;
			end
			OP_NOT: res_d = {31'd0, fin.a_zero};
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
			st_q  <= st_d;
		end
	end

	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && st_q != ST_OK |-> res_q == '0) else $error("nonzero result on error");
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[N] && !en |=> vld_q[N]) else $error("stalled item lost");
	a_divz_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[N] && st_d == ST_DIVZ |-> fin.b_zero) else $error("divide by zero flag without zero divisor");

endmodule
`default_nettype wire

@@ sv/checked_int32_alu.sv @@
// path from input transaction to result: front register, queue slot, multiplier load
//   stage, 32 divider stages, output register; throughput: one transaction per cycle
// unless the output is held; the 32-stage restoring divider is fully pipelined
// a held output stalls the whole back pipeline; the front keeps filling the queue meanwhile
// reset: arst_n clears all valid bits and queue pointers; no data is cleared
`default_nettype none
module checked_int32_alu #(
	parameter int unsigned QUEUE_DEPTH = cia_pkg::QueueDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // func[2:0], a[34:3], b[66:35], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // result[31:0], status[33:32], zero pad
);
	import cia_pkg::*;

	fe_item_t    fe_item;
	fe_item_t    hd_item;
	logic        push;
	logic        full;
	logic        not_empty;
	logic        pop;
	logic [31:0] res;
	logic [1:0]  st;

	// front: decode, magnitudes, add/subtract sum
	cia_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.func     (s_tdata[2:0]),
		.a        (s_tdata[34:3]),
		.b        (s_tdata[66:35]),
		.push     (push),
		.full     (full),
		.item     (fe_item)
	);

	// short queue decouples front from back stalls
	cia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (fe_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_item   (hd_item)
	);

	// back: multiply, divide pipeline, result select
	cia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_pop     (pop),
		.q_item    (hd_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (res),
		.status    (st)
	);

	assign m_tdata = {6'd0, st, res};

endmodule
`default_nettype wire

@@ tb/cia_checker.sv @@
`timescale 1ns / 100ps
module cia_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [71:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	output int               fail_count,
	output int               pending
);
	import cia_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		status_t     st;
	} alu_out_t;

	alu_out_t expected_q[$];

	function automatic alu_out_t range_fold(longint r, bit low_under);
		alu_out_t o;
		o.value = '0;
		if (r > 64'sd2147483647) o.st = ST_OVER;
		else if (r < -64'sd2147483648) o.st = low_under ? ST_UNDER : ST_OVER;
		else begin
			o.st = ST_OK;
			o.value = r[31:0];
		end
		return o;
	endfunction

	function automatic alu_out_t predict_alu(logic [2:0] op, logic signed [31:0] a,
		logic signed [31:0] b);
		alu_out_t o;
		longint la, lb;
		la = a;
		lb = b;
		o.value = '0;
		o.st = ST_OK;
		case (op)
			OP_ADD: o = range_fold(la + lb, 1'b1);
			OP_SUB: o = range_fold(la - lb, 1'b1);
			OP_MUL: o = range_fold(la * lb, 1'b0);
			OP_DIV: begin
				if (b == 0) o.st = ST_DIVZ;
				else if (la == -64'sd2147483648 && b == -1) o.st = ST_OVER;
				else begin
					la = la / lb;
					o.value = la[31:0];
				end
			end
			OP_MOD: begin
				if (b == 0) o.st = ST_DIVZ;
				else if (b != -1) begin
					la = la % lb;
					o.value = la[31:0];
				end
			end
			OP_NOT: o.value = (a == 0) ? 32'd1 : 32'd0;
			default: ;
		endcase
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		alu_out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_alu(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35]));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) $display("result with nothing expected: %h", m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.st
						|| m_tdata[39:34] !== 6'd0) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected result %h status %0d, got %h status %0d",
								want.value, want.st, m_tdata[31:0], m_tdata[33:32]);
					end
				end
			end
		end
	end
endmodule

@@ tb/tb_checked_int32_alu.sv @@
`timescale 1ns / 100ps
module tb_checked_int32_alu;
	import cia_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // func[2:0], a[34:3], b[66:35], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // result[31:0], status[33:32], zero pad
	int          fail_count;
	int          pending;
	int          cycle_count;

	// idle percentages for the sender and the receiver
	int unsigned send_idle;
	int unsigned recv_idle;
	// long receiver hold-off, counted down in the receiver process
	int          hold_cycles;
	int          sent;

	checked_int32_alu dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	cia_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: generous against the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// operand biased toward the interesting corners
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return 32'd1;
			5, 6: return $urandom_range(65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// offers one transaction, with an optional idle gap first, and waits for acceptance;
	// ready is looked at mid-cycle so the value seen is the one the next edge uses
	task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, b, a, op};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase(int n, int unsigned si, int unsigned ri);
		logic [2:0] op;
		send_idle = si;
		recv_idle = ri;
		repeat (n) begin
			op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
			send_op(op, pick_operand(), pick_operand());
		end
	endtask

	initial begin
		logic [31:0] mn;
		logic [31:0] mx;
		mn = 32'h8000_0000;
		mx = 32'h7fff_ffff;
		cycle_count = 0;
		sent = 0;
		hold_cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: limits of add/sub, mul overflow, div and mod specials
		send_op(OP_ADD, mx, 32'd1);
		send_op(OP_ADD, mn, 32'hffff_ffff);
		send_op(OP_ADD, mx, mn);
		send_op(OP_SUB, mn, 32'd1);
		send_op(OP_SUB, mx, 32'hffff_ffff);
		send_op(OP_SUB, 32'd0, mn);
		send_op(OP_MUL, mx, 32'd2);
		send_op(OP_MUL, mn, 32'hffff_ffff);
		send_op(OP_MUL, mn, 32'd1);
		send_op(OP_MUL, 32'h0001_0000, 32'hffff_0000);
		send_op(OP_MUL, 32'h0001_0000, 32'h0001_0000);
		send_op(OP_DIV, mx, 32'd0);
		send_op(OP_DIV, mn, 32'hffff_ffff);
		send_op(OP_DIV, 32'hffff_fff9, 32'd2);
		send_op(OP_DIV, mn, mn);
		send_op(OP_MOD, mn, 32'hffff_ffff);
		send_op(OP_MOD, 32'd5, 32'd0);
		send_op(OP_MOD, 32'hffff_fff9, 32'd2);
		send_op(OP_MOD, 32'd7, 32'hffff_fffe);
		send_op(OP_NOT, 32'd0, mx);
		send_op(OP_NOT, mn, 32'd0);
		send_op(3'd6, mx, mx);
		send_op(3'd7, mn, mn);
		drain();

		// idling phases: none, sender, receiver, both
		random_phase(450, 0, 0);
		random_phase(450, 54, 0);
		random_phase(450, 0, 54);
		random_phase(450, 8, 8);

		// long receiver hold-off while the sender keeps offering, so input stalls
		drain();
		hold_cycles = 200;
		random_phase(100, 0, 0);
		drain();
		repeat (60) @(posedge clk);

		$display("ran %0d alu transactions over all opcodes, operand corners and", sent);
		$display("idle/stall phases including a full back-pressure stretch");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
